// File: hdl/wsf_pkg.sv
// Shared widths, register codes and reset values of the weighted 3x3 smoothing filter.
package wsf_pkg;

	localparam int PIX_W   = 8;
	localparam int POS_W   = 10;
	localparam int NTAPS   = 9;
	localparam int WT_W    = 4;
	localparam int KERN_W  = NTAPS * WT_W;
	localparam int DIM_W   = 11;
	localparam int PROD_W  = PIX_W + WT_W;
	localparam int SUM_W   = 16;
	localparam int WSUM_W  = 8;
	localparam int APB_DW  = 64;
	localparam int APB_AW  = 5;

	localparam logic [KERN_W-1:0] KERNEL_RESET = 36'h141484141;
	localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd480;

	typedef enum logic [1:0] {
		REG_KERNEL = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

endpackage

// File: hdl/wsf_pix_if.sv
// Pixel input channel: valid/ready handshake carrying one pixel item.
interface wsf_pix_if;
	import wsf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

// File: hdl/wsf_res_if.sv
// Result output channel: valid/ready handshake carrying one filtered pixel item.
interface wsf_res_if;
	import wsf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] value;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic             last_of_frame;
	logic             weight_error;

	modport source (output valid, output value, output out_row, output out_col,
		output last_of_frame, output weight_error, input ready);
	modport sink   (input valid, input value, input out_row, input out_col,
		input last_of_frame, input weight_error, output ready);

endinterface

// File: hdl/weighted_3x3_smoothing_filter.sv
// Weighted 3x3 smoothing filter over a raster pixel stream (top level).
//
// Pixels enter on pix in raster order; frame_start puts an item at row 0, column 0.
// For every interior pixel one item leaves on res: the weighted 3x3 sum divided
// (truncating) by the weight sum, with the center row/column, a last-of-frame mark
// and weight_error when the weights sum to zero (value is then 0).
// Registers sit on an APB port at byte addresses 0 (kernel_weights), 8 (image_width)
// and 16 (image_height); write them only while the block is idle.
// A border pixel goes through a line memory read, then write-back. An interior
// pixel goes through read, multiply, sum, 8 restoring divider steps and the
// result load; with a zero weight sum the divider is skipped. The line memory is
// single-port and the divider gives one quotient bit per cycle. pix.ready is high
// only while idle, so a new pixel is taken only after the last one is through.
// A result waits in the output register while res.ready is low and the next pixel
// is still taken; a second result then holds until the first one leaves.
// Reset clears the window, the position counters and the registers to their
// defaults (weights 1,4,1,4,8,4,1,4,1, 640x480); the line memory is not cleared.
module weighted_3x3_smoothing_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	wsf_pix_if.sink                    pix,
	wsf_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wsf_pkg::APB_AW-1:0] paddr,
	input  logic [wsf_pkg::APB_DW-1:0] pwdata,
	output logic [wsf_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import wsf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	// configuration registers
	logic [KERN_W-1:0] kern_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	reg_idx_t          cfg_idx;
	logic              cfg_wr;

	assign cfg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q   <= KERNEL_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KERNEL: kern_q   <= pwdata[KERN_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_KERNEL: prdata = APB_DW'(kern_q);
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			default:    prdata = '0;
		endcase
	end

	// effective frame size, clamped to 3..MAX
	logic [31:0]   w_raw, h_raw;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	assign w_raw = 32'(width_q);
	assign h_raw = 32'(height_q);

	always_comb begin
		if (w_raw < 32'd3)
			w_eff = WW'(3);
		else if (w_raw > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(w_raw);
		if (h_raw < 32'd3)
			h_eff = HW'(3);
		else if (h_raw > 32'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(h_raw);
	end

	state_t state_q;

	// item and position registers
	logic [CW-1:0]    col_cnt_q;
	logic [RW-1:0]    row_cnt_q;
	logic [CW-1:0]    item_c_q;
	logic [RW-1:0]    item_r_q;
	logic [PIX_W-1:0] item_pix_q;
	logic             accept;

	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;

	// line memory: upper row in the high byte, middle row in the low byte
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] mem_rd_q;
	logic [CW-1:0]      rd_addr;
	logic               wr_en;
	logic [PIX_W-1:0]   top, mid;

	assign rd_addr = pix.frame_start ? '0 : col_cnt_q;
	assign wr_en   = (state_q == ST_RD);
	assign top     = mem_rd_q[2*PIX_W-1:PIX_W];
	assign mid     = mem_rd_q[PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (accept)
			mem_rd_q <= line_mem[rd_addr];
		if (wr_en)
			line_mem[item_c_q] <= {mid, item_pix_q};
	end

	// position bookkeeping for the item in ST_RD
	logic [31:0] cx, rx, wx, hx;
	logic [31:0] nc, nr;
	logic        emit;

	assign cx = 32'(item_c_q);
	assign rx = 32'(item_r_q);
	assign wx = 32'(w_eff);
	assign hx = 32'(h_eff);
	assign emit = (rx >= 32'd2) && (cx >= 32'd2) && (rx < hx) && (cx < wx);

	always_comb begin
		nc = cx + 32'd1;
		nr = rx;
		if (cx + 32'd1 >= wx) begin
			nc = '0;
			nr = (rx + 32'd1 >= hx) ? '0 : rx + 32'd1;
		end
		if (nr >= hx)
			nr = '0;
	end

	// window, products, divider
	logic [PIX_W-1:0]  win_q    [NTAPS];
	logic [PROD_W-1:0] prod_s1  [NTAPS];
	logic [SUM_W-1:0]  sum_c;
	logic [WSUM_W-1:0] wsum_c;
	logic [WSUM_W-1:0] div_d_q;
	logic [PIX_W-1:0]  rem_q;
	logic [PIX_W-1:0]  sh_q;
	logic [PIX_W-1:0]  quo_q;
	logic [2:0]        div_cnt_q;
	logic              err_q;
	logic [POS_W-1:0]  meta_row_q, meta_col_q;
	logic              meta_last_q;
	logic [PIX_W:0]    trial;
	logic              qbit;

	always_comb begin
		sum_c  = '0;
		wsum_c = '0;
		for (int k = 0; k < NTAPS; k++) begin
			sum_c  = sum_c + SUM_W'(prod_s1[k]);
			wsum_c = wsum_c + WSUM_W'(kern_q[WT_W*k +: WT_W]);
		end
	end

	assign trial = {rem_q, sh_q[PIX_W-1]};
	assign qbit  = (trial >= {1'b0, div_d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			for (int k = 0; k < NTAPS; k++)
				win_q[k] <= '0;
		end else if (state_q == ST_RD) begin
			col_cnt_q <= CW'(nc);
			row_cnt_q <= RW'(nr);
			for (int k = 0; k < NTAPS; k += 3) begin
				win_q[k]     <= win_q[k + 1];
				win_q[k + 1] <= win_q[k + 2];
			end
			win_q[2] <= top;
			win_q[5] <= mid;
			win_q[8] <= item_pix_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_pix_q <= pix.pixel;
			item_c_q   <= pix.frame_start ? '0 : col_cnt_q;
			item_r_q   <= pix.frame_start ? '0 : row_cnt_q;
		end
		if (state_q == ST_RD) begin
			meta_row_q  <= POS_W'(rx - 32'd1);
			meta_col_q  <= POS_W'(cx - 32'd1);
			meta_last_q <= (rx == hx - 32'd1) && (cx == wx - 32'd1);
		end
		if (state_q == ST_MUL) begin
			for (int k = 0; k < NTAPS; k++)
				prod_s1[k] <= PROD_W'(kern_q[WT_W*k +: WT_W]) * PROD_W'(win_q[k]);
		end
		if (state_q == ST_SUM) begin
			// quotient fits in 8 bits, so the high byte is already below the divisor
			div_d_q   <= wsum_c;
			rem_q     <= sum_c[SUM_W-1:PIX_W];
			sh_q      <= sum_c[PIX_W-1:0];
			quo_q     <= '0;
			div_cnt_q <= '0;
			err_q     <= (wsum_c == '0);
		end
		if (state_q == ST_DIV) begin
			rem_q     <= qbit ? PIX_W'(trial - {1'b0, div_d_q}) : PIX_W'(trial);
			sh_q      <= {sh_q[PIX_W-2:0], 1'b0};
			quo_q     <= {quo_q[PIX_W-2:0], qbit};
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	// sequencer and output register
	logic             res_vld_q;
	logic [PIX_W-1:0] res_value_q;
	logic [POS_W-1:0] res_row_q, res_col_q;
	logic             res_last_q, res_err_q;
	logic             res_load;

	// load only when the output register is free or being emptied
	assign res_load = (state_q == ST_DONE) && (!res_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_vld_q   <= 1'b0;
			res_value_q <= '0;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_last_q  <= 1'b0;
			res_err_q   <= 1'b0;
		end else begin
			if (res_load)
				res_vld_q <= 1'b1;
			else if (res.ready)
				res_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= emit ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= (wsum_c == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == 3'd7)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (res_load) begin
						res_value_q <= err_q ? '0 : quo_q;
						res_row_q   <= meta_row_q;
						res_col_q   <= meta_col_q;
						res_last_q  <= meta_last_q;
						res_err_q   <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = res_vld_q;
	assign res.value         = res_value_q;
	assign res.out_row       = res_row_q;
	assign res.out_col       = res_col_q;
	assign res.last_of_frame = res_last_q;
	assign res.weight_error  = res_err_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("accepted item did not start a line memory read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_vld_q && !res.ready |=> state_q == ST_DONE)
		else $error("result loaded over a waiting result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_err_q |-> res_value_q == '0)
		else $error("weight error with nonzero value");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_d_q)
		else $error("divider remainder out of range");

endmodule

// File: tb/sv/tb_weighted_3x3_smoothing_filter.sv
// Self-checking testbench for the weighted 3x3 smoothing filter: directed table, random frames.
module tb_weighted_3x3_smoothing_filter;
	import wsf_pkg::*;

	localparam int MAXW         = 1024;
	localparam int MAXH         = 1024;
	localparam int DRAIN_CYCLES = 20;
	localparam int RAND_ITEMS   = 1780;
	localparam int QUIET_ITEMS  = 200;
	localparam int DIR_N        = 25;
	localparam int PREFILL_W    = 14;
	localparam logic [KERN_W-1:0] KERN_FULL = '1;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             err;
	} smooth_res_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic              fs;
		logic [KERN_W-1:0] kern;
		logic [DIM_W-1:0]  wid;
		logic [DIM_W-1:0]  hgt;
		logic              typed;
		smooth_res_t       want;
	} dir_row_t;

	localparam smooth_res_t NO_RES = '0;

	// Flat 255 field, zero weight sum, then full weights on a clamped size.
	localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
		'{8'hFF, 1'b1, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERNEL_RESET, 11'd3, 11'd3, 1'b1,
			'{8'd255, 10'd1, 10'd1, 1'b1, 1'b0}},
		// no frame_start: position has wrapped to the frame origin
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b0, NO_RES},
		'{8'h00, 1'b0, 36'h0, 11'd3, 11'd3, 1'b1,
			'{8'd0, 10'd1, 10'd1, 1'b1, 1'b1}},
		'{8'h80, 1'b1, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'h01, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'hFE, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'h7F, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'h00, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES},
		'{8'h55, 1'b0, KERN_FULL, 11'd2, 11'd0, 1'b0, NO_RES}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	wsf_pix_if pix ();
	wsf_res_if res ();

	weighted_3x3_smoothing_filter #(
		.MAX_WIDTH (MAXW),
		.MAX_HEIGHT(MAXH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Filter state mirrored by the predictor
	logic [PIX_W-1:0]  ln_up  [MAXW];
	logic [PIX_W-1:0]  ln_mid [MAXW];
	logic [PIX_W-1:0]  win    [NTAPS];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [KERN_W-1:0] cfg_kern;
	logic [DIM_W-1:0]  cfg_wid;
	logic [DIM_W-1:0]  cfg_hgt;

	smooth_res_t filtered_q [$];

	bit src_gap_on;
	bit sink_stall_on;
	int fail_cnt    = 0;
	int n_items     = 0;
	int n_results   = 0;
	int n_zero_wsum = 0;
	int n_frame_end = 0;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Advance the mirrored window by one pixel; return 1 with the filtered result
	// when the center is an interior pixel of the current size.
	function automatic bit smooth_pixel(input logic [PIX_W-1:0] p, input logic fs,
		output smooth_res_t r);
		int unsigned w, h, rr, cc, sum, wsum, wt;
		logic [PIX_W-1:0] top, mid;
		bit hit;
		w = clamp_dim(cfg_wid, MAXW);
		h = clamp_dim(cfg_hgt, MAXH);
		top = '0;
		mid = '0;
		hit = 0;
		r = '0;
		if (fs) begin
			rr = 0;
			cc = 0;
		end else begin
			rr = row_pos;
			cc = col_pos;
		end
		if (cc < MAXW) begin
			top = ln_up[cc];
			mid = ln_mid[cc];
			ln_up[cc] = mid;
			ln_mid[cc] = p;
		end
		for (int k = 0; k < NTAPS; k += 3) begin
			win[k] = win[k+1];
			win[k+1] = win[k+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = p;
		if (rr >= 2 && cc >= 2 && rr < h && cc < w) begin
			sum = 0;
			wsum = 0;
			for (int k = 0; k < NTAPS; k++) begin
				wt = cfg_kern[WT_W*k +: WT_W];
				sum += wt * win[k];
				wsum += wt;
			end
			r.err = (wsum == 0);
			r.value = (wsum == 0) ? '0 : PIX_W'(sum / wsum);
			r.row = POS_W'(rr - 1);
			r.col = POS_W'(cc - 1);
			r.last = (rr == h - 1 && cc == w - 1);
			hit = 1;
		end
		if (cc + 1 >= w) begin
			cc = 0;
			rr = (rr + 1 >= h) ? 0 : rr + 1;
		end else begin
			cc = cc + 1;
		end
		if (rr >= h)
			rr = 0;
		col_pos = cc;
		row_pos = rr;
		return hit;
	endfunction

	function automatic logic [KERN_W-1:0] rand_kern();
		logic [KERN_W-1:0] k;
		case ($urandom_range(0, 5))
			0: k = KERNEL_RESET;
			1: k = '0;
			2: k = KERN_FULL;
			3: begin
				// one active tap
				k = '0;
				k[WT_W*$urandom_range(0, NTAPS-1) +: WT_W] = WT_W'($urandom_range(1, 15));
			end
			default: k = KERN_W'({$urandom, $urandom});
		endcase
		return k;
	endfunction

	task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'(int'(idx) * 8);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic check_regs();
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] want [3];
		want[REG_KERNEL] = APB_DW'(cfg_kern);
		want[REG_WIDTH] = APB_DW'(cfg_wid);
		want[REG_HEIGHT] = APB_DW'(cfg_hgt);
		for (int i = 0; i < 3; i++) begin
			apb_access(reg_idx_t'(i), 1'b0, '0, rd);
			if (rd !== want[i]) begin
				$display("%0t: register %0d read expected 0x%0h got 0x%0h", $time, i, want[i], rd);
				fail_cnt++;
			end
		end
	endtask

	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		// border pixels leave no result; let the pipe empty
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_filter(input logic [KERN_W-1:0] kern, input logic [DIM_W-1:0] wid,
		input logic [DIM_W-1:0] hgt);
		logic [APB_DW-1:0] rd;
		wait_drained();
		apb_access(REG_KERNEL, 1'b1, APB_DW'(kern), rd);
		apb_access(REG_WIDTH, 1'b1, APB_DW'(wid), rd);
		apb_access(REG_HEIGHT, 1'b1, APB_DW'(hgt), rd);
		cfg_kern = kern;
		cfg_wid = wid;
		cfg_hgt = hgt;
		check_regs();
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs, input bit typed,
		input smooth_res_t want);
		smooth_res_t r;
		bit hit;
		if (src_gap_on && $urandom_range(0, 5) == 0) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= p;
		pix.frame_start <= fs;
		do @(posedge clk); while (!pix.ready);
		hit = smooth_pixel(p, fs, r);
		if (typed)
			filtered_q.push_back(want);
		else if (hit)
			filtered_q.push_back(r);
		n_items++;
	endtask

	task automatic run_frame(input int npix, input bit first_fs, input bit noise);
		logic [PIX_W-1:0] p;
		logic fs;
		for (int i = 0; i < npix; i++) begin
			fs = (i == 0 && first_fs) || (noise && $urandom_range(0, 15) == 0);
			case ($urandom_range(0, 7))
				0: p = '0;
				1: p = '1;
				default: p = PIX_W'($urandom);
			endcase
			send_pixel(p, fs, 1'b0, NO_RES);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb_weighted_3x3_smoothing_filter: FAIL");
		$finish;
	end

	// Result sink: ready drops in bursts while stalling is enabled
	initial begin
		int stall;
		stall = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				if (stall == 0)
					res.ready <= 1'b1;
			end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
				res.ready <= 1'b0;
				stall = $urandom_range(1, 9);
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : res_check
		smooth_res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.value, res.out_row, res.out_col, res.last_of_frame, res.weight_error};
			n_results++;
			if (got.err)
				n_zero_wsum++;
			if (got.last)
				n_frame_end++;
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result value %0d row %0d col %0d last %0b err %0b",
					$time, got.value, got.row, got.col, got.last, got.err);
				fail_cnt++;
			end else begin
				want = filtered_q.pop_front();
				if (got !== want) begin
					// fields in order value, row, col, last, err
					$display("%0t: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
						$time, want.value, want.row, want.col, want.last, want.err,
						got.value, got.row, got.col, got.last, got.err);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		int unsigned w_raw, h_raw, fsz, n, kind;
		int rand_items, phases;
		rand_items = 0;
		phases = 0;
		src_gap_on = 0;
		sink_stall_on = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix.valid <= 1'b0;
		pix.pixel <= '0;
		pix.frame_start <= 1'b0;
		for (int i = 0; i < MAXW; i++) begin
			ln_up[i] = '0;
			ln_mid[i] = '0;
		end
		for (int k = 0; k < NTAPS; k++)
			win[k] = '0;
		col_pos = 0;
		row_pos = 0;
		cfg_kern = KERNEL_RESET;
		cfg_wid = WIDTH_RESET;
		cfg_hgt = HEIGHT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_regs();
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].kern != cfg_kern || DIR_TAB[i].wid != cfg_wid ||
				DIR_TAB[i].hgt != cfg_hgt)
				set_filter(DIR_TAB[i].kern, DIR_TAB[i].wid, DIR_TAB[i].hgt);
			send_pixel(DIR_TAB[i].pix, DIR_TAB[i].fs, DIR_TAB[i].typed, DIR_TAB[i].want);
		end

		// Widest random frame first: it fills every line store entry that a random
		// width can reach before any mid-frame resize
		src_gap_on = 1'($urandom_range(0, 1));
		sink_stall_on = 1'($urandom_range(0, 1));
		set_filter(rand_kern(), DIM_W'(PREFILL_W), 11'd3);
		run_frame(PREFILL_W * 3, 1'b1, 1'b0);

		while (rand_items < RAND_ITEMS) begin
			if (rand_items >= RAND_ITEMS - QUIET_ITEMS) begin
				src_gap_on = 0;
				sink_stall_on = 0;
			end else begin
				src_gap_on = ($urandom_range(0, 3) != 0);
				sink_stall_on = ($urandom_range(0, 3) != 0);
			end
			w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, PREFILL_W);
			h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			set_filter(rand_kern(), DIM_W'(w_raw), DIM_W'(h_raw));
			fsz = clamp_dim(w_raw, MAXW) * clamp_dim(h_raw, MAXH);
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				n = fsz;
				run_frame(n, 1'b1, 1'b0);
			end else if (kind < 15) begin
				// stop mid-frame so the next setting lands inside it
				n = $urandom_range(1, fsz - 1);
				run_frame(n, 1'b1, 1'b0);
			end else if (kind < 17) begin
				n = $urandom_range(1, 2 * fsz);
				run_frame(n, 1'b0, 1'b0);
			end else begin
				n = $urandom_range(1, 2 * fsz);
				run_frame(n, 1'($urandom_range(0, 1)), 1'b1);
			end
			rand_items += n;
			phases++;
		end

		wait_drained();
		$display("Sent %0d pixel items (%0d in %0d small random phases after a prefill frame)",
			n_items, rand_items, phases);
		$display("Checked %0d results: %0d with zero weight sum, %0d frame ends",
			n_results, n_zero_wsum, n_frame_end);
		if (fail_cnt == 0)
			$display("tb_weighted_3x3_smoothing_filter: PASS");
		else
			$display("tb_weighted_3x3_smoothing_filter: FAIL");
		$finish;
	end

endmodule

// File: files.f
hdl/wsf_pkg.sv
hdl/wsf_pix_if.sv
hdl/wsf_res_if.sv
hdl/weighted_3x3_smoothing_filter.sv
tb/sv/tb_weighted_3x3_smoothing_filter.sv
